[rtl/acr_pkg.sv]
// ----------------------------------------------------------------------------
// acr_pkg
// shared types and constants of the box collision resolver
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SCREEN_W_RST   = 5120;
  localparam int SCREEN_H_RST   = 3840;
  localparam int NUM_DIRS       = 4;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_H = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLR_MASK = 2'd1,
    OP_CLAMP    = 2'd2,
    OP_PUSH     = 2'd3
  } acr_op_e;

  typedef struct packed {
    logic [NUM_DIRS-1:0] hit;
    logic                ov;
  } acr_flags_t;

endpackage

[rtl/acr_if.sv]
// ----------------------------------------------------------------------------
// acr_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface acr_in_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [CW-1:0] box_x;
  logic signed [CW-1:0] box_y;
  logic [CW-2:0]        box_w;
  logic [CW-2:0]        box_h;
  logic [3:0]           check_dirs;

  modport source (
    output valid, opcode, box_x, box_y, box_w, box_h, check_dirs,
    input  ready
  );
  modport sink (
    input  valid, opcode, box_x, box_y, box_w, box_h, check_dirs,
    output ready
  );
endinterface

interface acr_out_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic [3:0]           hit_dirs;
  logic [3:0]           collision_mask;
  logic                 overlapped;

  modport source (
    output valid, pos_x, pos_y, hit_dirs, collision_mask, overlapped,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, hit_dirs, collision_mask, overlapped,
    output ready
  );
endinterface

[rtl/acr_clamp.sv]
// ----------------------------------------------------------------------------
// acr_clamp
// keeps the object box inside the screen for the selected edges
// ----------------------------------------------------------------------------
module acr_clamp
  import acr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] obj_x_i,
  input  logic signed [COORD_BITS-1:0] obj_y_i,
  input  logic [COORD_BITS-2:0]        obj_w_i,
  input  logic [COORD_BITS-2:0]        obj_h_i,
  input  logic [COORD_BITS-2:0]        scr_w_i,
  input  logic [COORD_BITS-2:0]        scr_h_i,
  input  logic [NUM_DIRS-1:0]          dirs_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output acr_flags_t                   flags_o
);

  localparam int C = COORD_BITS;

  logic                 left_hit, right_hit, up_hit, down_hit;
  logic signed [C-1:0]  x1, y1;
  logic signed [C:0]    x_edge, y_edge;
  logic signed [C-1:0]  x_max, y_max;

  assign left_hit = dirs_i[DIR_LEFT] & obj_x_i[C-1];
  assign x1       = left_hit ? '0 : obj_x_i;
  assign x_edge   = {x1[C-1], x1} + $signed({2'b00, obj_w_i});
  assign x_max    = {1'b0, scr_w_i} - {1'b0, obj_w_i};
  assign right_hit = dirs_i[DIR_RIGHT] & (x_edge > $signed({2'b00, scr_w_i}));

  assign up_hit   = dirs_i[DIR_UP] & obj_y_i[C-1];
  assign y1       = up_hit ? '0 : obj_y_i;
  assign y_edge   = {y1[C-1], y1} + $signed({2'b00, obj_h_i});
  assign y_max    = {1'b0, scr_h_i} - {1'b0, obj_h_i};
  assign down_hit = dirs_i[DIR_DOWN] & (y_edge > $signed({2'b00, scr_h_i}));

  always_comb begin
    pos_x_o = right_hit ? x_max : x1;
    pos_y_o = down_hit ? y_max : y1;
    flags_o.hit = '0;
    flags_o.hit[DIR_LEFT]  = left_hit;
    flags_o.hit[DIR_RIGHT] = right_hit;
    flags_o.hit[DIR_UP]    = up_hit;
    flags_o.hit[DIR_DOWN]  = down_hit;
    flags_o.ov = 1'b0;
  end

endmodule

[rtl/acr_push.sv]
// ----------------------------------------------------------------------------
// acr_push
// overlap test and minimum penetration push-out against one box
// ----------------------------------------------------------------------------
module acr_push
  import acr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] obj_x_i,
  input  logic signed [COORD_BITS-1:0] obj_y_i,
  input  logic [COORD_BITS-2:0]        obj_w_i,
  input  logic [COORD_BITS-2:0]        obj_h_i,
  input  logic signed [COORD_BITS-1:0] box_x_i,
  input  logic signed [COORD_BITS-1:0] box_y_i,
  input  logic [COORD_BITS-2:0]        box_w_i,
  input  logic [COORD_BITS-2:0]        box_h_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output acr_flags_t                   flags_o
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 2;
  localparam logic signed [E-1:0] MAX_E = {3'b000, {(C-1){1'b1}}};
  localparam logic signed [E-1:0] MIN_E = {3'b111, {(C-1){1'b0}}};

  function automatic logic signed [C-1:0] sat_c(input logic signed [E-1:0] v);
    logic signed [C-1:0] r;
    if (v > MAX_E) begin
      r = MAX_E[C-1:0];
    end else if (v < MIN_E) begin
      r = MIN_E[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  logic signed [E-1:0] ox, oy, ow, oh, bx, by, bw, bh;
  logic signed [E-1:0] ox_r, oy_b, bx_r, by_b;
  logic signed [E-1:0] pen_up, pen_dn, pen_lf, pen_rt, best;
  logic [1:0]          win;
  logic                hit_any;

  assign ox = {{2{obj_x_i[C-1]}}, obj_x_i};
  assign oy = {{2{obj_y_i[C-1]}}, obj_y_i};
  assign bx = {{2{box_x_i[C-1]}}, box_x_i};
  assign by = {{2{box_y_i[C-1]}}, box_y_i};
  assign ow = {3'b000, obj_w_i};
  assign oh = {3'b000, obj_h_i};
  assign bw = {3'b000, box_w_i};
  assign bh = {3'b000, box_h_i};

  assign ox_r = ox + ow;
  assign oy_b = oy + oh;
  assign bx_r = bx + bw;
  assign by_b = by + bh;

  assign hit_any = (ox <= bx_r) && (ox_r >= bx) && (oy <= by_b) && (oy_b >= by);

  assign pen_up = by_b - oy;
  assign pen_dn = oy_b - by;
  assign pen_lf = bx_r - ox;
  assign pen_rt = ox_r - bx;

  // smallest penetration, lower direction wins a tie
  always_comb begin
    best = pen_up;
    win  = DIR_UP;
    if (pen_dn < best) begin
      best = pen_dn;
      win  = DIR_DOWN;
    end
    if (pen_lf < best) begin
      best = pen_lf;
      win  = DIR_LEFT;
    end
    if (pen_rt < best) begin
      best = pen_rt;
      win  = DIR_RIGHT;
    end
  end

  always_comb begin
    pos_x_o = obj_x_i;
    pos_y_o = obj_y_i;
    flags_o.hit = '0;
    flags_o.ov  = hit_any;
    if (hit_any) begin
      flags_o.hit[win] = 1'b1;
      case (win)
        DIR_UP:    pos_y_o = sat_c(by_b);
        DIR_DOWN:  pos_y_o = sat_c(by - oh);
        DIR_LEFT:  pos_x_o = sat_c(bx_r);
        default:   pos_x_o = sat_c(bx - ow);
      endcase
    end
  end

endmodule

[rtl/aabb_collision_resolver_core.sv]
// ----------------------------------------------------------------------------
// aabb_collision_resolver_core
// single-object box collision resolver with sticky collision mask
// ----------------------------------------------------------------------------
// Command words come in on item_i (load box, clear mask, clamp to screen,
// push out of a box) and every word gives exactly one result word on
// result_o: object position, directions hit by this word, the sticky mask
// and the overlap flag. Both channels are valid/ready.
// A word is held in an input register while the clamp or push logic runs
// on it; the object state and result register then update together, and
// one word per cycle is sustained while result_o is not stalled.
// The following word already sees the updated object state.
// When result_o stalls, the input register holds one more word and item_i
// drops ready until the result is taken.
// Screen width and height are written via cfg_we_i / cfg_idx_i / cfg_data_i
// by the user only while idle, which the block does not enforce; writes to unknown indexes are dropped.
// Reset clears the object box and mask to zero, restores the screen size
// defaults and empties both registers.
// ----------------------------------------------------------------------------
module aabb_collision_resolver_core
  import acr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-2:0]   cfg_data_i,
  acr_in_if.sink                  item_i,
  acr_out_if.source               result_o
);

  localparam int C = COORD_BITS;

  logic                in_valid_q, out_valid_q;
  logic                advance;
  acr_op_e             op_q;
  logic signed [C-1:0] bx_q, by_q;
  logic [C-2:0]        bw_q, bh_q;
  logic [NUM_DIRS-1:0] dirs_q;

  logic [C-2:0]        scr_w_q, scr_h_q;
  logic signed [C-1:0] obj_x_q, obj_y_q, obj_x_d, obj_y_d;
  logic [C-2:0]        obj_w_q, obj_h_q, obj_w_d, obj_h_d;
  logic [NUM_DIRS-1:0] mask_q, mask_d;

  logic signed [C-1:0] clamp_x, clamp_y, push_x, push_y;
  acr_flags_t          clamp_flags, push_flags, flags_d;

  logic signed [C-1:0] res_x_q, res_y_q;
  logic [NUM_DIRS-1:0] res_hit_q, res_mask_q;
  logic                res_ov_q;

  assign advance      = in_valid_q & (~out_valid_q | result_o.ready);
  assign item_i.ready = ~in_valid_q | advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= (C-1)'(SCREEN_W_RST);
      scr_h_q <= (C-1)'(SCREEN_H_RST);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SCREEN_W) begin
        scr_w_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_SCREEN_H) begin
        scr_h_q <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      op_q   <= acr_op_e'(item_i.opcode);
      bx_q   <= item_i.box_x;
      by_q   <= item_i.box_y;
      bw_q   <= item_i.box_w;
      bh_q   <= item_i.box_h;
      dirs_q <= item_i.check_dirs;
    end
  end

  acr_clamp #(
    .COORD_BITS(COORD_BITS)
  ) u_clamp (
    .obj_x_i (obj_x_q),
    .obj_y_i (obj_y_q),
    .obj_w_i (obj_w_q),
    .obj_h_i (obj_h_q),
    .scr_w_i (scr_w_q),
    .scr_h_i (scr_h_q),
    .dirs_i  (dirs_q),
    .pos_x_o (clamp_x),
    .pos_y_o (clamp_y),
    .flags_o (clamp_flags)
  );

  acr_push #(
    .COORD_BITS(COORD_BITS)
  ) u_push (
    .obj_x_i (obj_x_q),
    .obj_y_i (obj_y_q),
    .obj_w_i (obj_w_q),
    .obj_h_i (obj_h_q),
    .box_x_i (bx_q),
    .box_y_i (by_q),
    .box_w_i (bw_q),
    .box_h_i (bh_q),
    .pos_x_o (push_x),
    .pos_y_o (push_y),
    .flags_o (push_flags)
  );

  always_comb begin
    obj_x_d = obj_x_q;
    obj_y_d = obj_y_q;
    obj_w_d = obj_w_q;
    obj_h_d = obj_h_q;
    flags_d = '0;
    mask_d  = mask_q;
    case (op_q)
      OP_LOAD: begin
        obj_x_d = bx_q;
        obj_y_d = by_q;
        obj_w_d = bw_q;
        obj_h_d = bh_q;
      end
      OP_CLR_MASK: begin
        mask_d = '0;
      end
      OP_CLAMP: begin
        obj_x_d = clamp_x;
        obj_y_d = clamp_y;
        flags_d = clamp_flags;
      end
      OP_PUSH: begin
        obj_x_d = push_x;
        obj_y_d = push_y;
        flags_d = push_flags;
      end
      default: begin
        flags_d = '0;
      end
    endcase
    mask_d = mask_d | flags_d.hit;
  end

  // object state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_x_q <= '0;
      obj_y_q <= '0;
      obj_w_q <= '0;
      obj_h_q <= '0;
      mask_q  <= '0;
    end else if (advance) begin
      obj_x_q <= obj_x_d;
      obj_y_q <= obj_y_d;
      obj_w_q <= obj_w_d;
      obj_h_q <= obj_h_d;
      mask_q  <= mask_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_x_q    <= obj_x_d;
      res_y_q    <= obj_y_d;
      res_hit_q  <= flags_d.hit;
      res_mask_q <= mask_d;
      res_ov_q   <= flags_d.ov;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.pos_x          = res_x_q;
  assign result_o.pos_y          = res_y_q;
  assign result_o.hit_dirs       = res_hit_q;
  assign result_o.collision_mask = res_mask_q;
  assign result_o.overlapped     = res_ov_q;

  a_push_one_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_ov_q) |-> $onehot(res_hit_q))
    else $error("push result without exactly one hit direction");

  a_hit_in_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_hit_q & ~res_mask_q) == '0))
    else $error("hit direction missing from sticky mask");

  a_result_from_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a held input word");

endmodule
